FILE: hdl/greedy_pair_select_invalidate_unit_macros.svh
// Assertion macros used by the checker file of the pair select unit.
// Depends on nothing; each file that asserts includes it by name.
`ifndef GREEDY_PAIR_SELECT_INVALIDATE_UNIT_MACROS_SVH
`define GREEDY_PAIR_SELECT_INVALIDATE_UNIT_MACROS_SVH

// Property checked on every rising clock edge except while reset is held.
`define GPSI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define GPSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/gpsi_pkg.sv
// Shared types and constants of the greedy pair select and invalidate unit.
// No dependencies; the module files reference it by scoped names.
package gpsi_pkg;

    // Fixed field widths of the item formats.
    localparam int SCORE_BITS  = 32;
    localparam int VAR_ID_BITS = 10;
    localparam int INDEX_BITS  = 8;
    localparam int CFG_BITS    = 9;

    // Item operation codes.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SELECT = 1'b1;

    // One input item.
    typedef struct packed {
        logic                          mode;
        logic [INDEX_BITS-1:0]         entry_index;
        logic signed [SCORE_BITS-1:0]  evidence_value;
        logic [VAR_ID_BITS-1:0]        first_var;
        logic [VAR_ID_BITS-1:0]        second_var;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic                          found;
        logic [INDEX_BITS-1:0]         best_index;
        logic signed [SCORE_BITS-1:0]  best_evidence;
        logic [VAR_ID_BITS-1:0]        best_first_var;
        logic [VAR_ID_BITS-1:0]        best_second_var;
    } t_out_item;

    // One table slot as held in the entry memory.
    typedef struct packed {
        logic                          valid;
        logic signed [SCORE_BITS-1:0]  score;
        logic [VAR_ID_BITS-1:0]        first_var;
        logic [VAR_ID_BITS-1:0]        second_var;
    } t_slot;

endpackage

FILE: hdl/gpsi_table.sv
// Entry memory of the pair select unit: one write port, one registered read port.
// Depends on gpsi_pkg for the slot format.
module gpsi_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  gpsi_pkg::t_slot      i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output gpsi_pkg::t_slot      o_rdata
);

    gpsi_pkg::t_slot r_mem [DEPTH];
    gpsi_pkg::t_slot r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/gpsi_pick.sv
// Shared compare unit: tracks the best slot during a search and flags
// slots whose pair conflicts with the chosen one. Depends on gpsi_pkg.
module gpsi_pick #(
    parameter int AW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_take,
    input  gpsi_pkg::t_slot      i_slot,
    input  logic [AW-1:0]        i_addr,
    output gpsi_pkg::t_out_item  o_best,
    output logic                 o_conflict
);

    gpsi_pkg::t_out_item r_best;
    gpsi_pkg::t_out_item n_best;
    logic                w_better;

    // A valid slot wins if nothing is held yet or its score is strictly greater,
    // so on equal scores the earlier index stays.
    assign w_better = i_slot.valid &&
                      (!r_best.found || (i_slot.score > r_best.best_evidence));

    always_comb begin
        n_best = r_best;
        if (i_clear) begin
            n_best = '0;
        end else if (i_take && w_better) begin
            n_best.found           = 1'b1;
            n_best.best_index      = gpsi_pkg::INDEX_BITS'(i_addr);
            n_best.best_evidence   = i_slot.score;
            n_best.best_first_var  = i_slot.first_var;
            n_best.best_second_var = i_slot.second_var;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else begin
            r_best <= n_best;
        end
    end

    // A live slot conflicts when it shares either variable with the held pair.
    assign o_conflict = i_slot.valid &&
                        ((i_slot.first_var  == r_best.best_first_var)  ||
                         (i_slot.second_var == r_best.best_first_var)  ||
                         (i_slot.first_var  == r_best.best_second_var) ||
                         (i_slot.second_var == r_best.best_second_var));

    assign o_best = r_best;

endmodule

FILE: hdl/greedy_pair_select_invalidate_unit.sv
// Top level of the greedy pair select and invalidate unit: sequencer, config register
// and output register. Depends on gpsi_pkg, gpsi_table and gpsi_pick.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------
//   input    | i_in_valid / o_in_stall   | i_in  (gpsi_pkg::t_in_item)
//   output   | o_out_valid / i_out_stall | o_out (gpsi_pkg::t_out_item)
//   config   | i_cfg_we                  | i_cfg_wdata (entries_in_use)
//
// A load transfer to an index inside the table writes the entry memory in the cycle it is taken.
// A select reads one slot per cycle through the single memory read port while it searches
// the first min(entries_in_use, TABLE_ENTRIES) slots; with entries_in_use zero nothing is read.
// When a slot is found a conflict sweep over all TABLE_ENTRIES slots follows, then the
// result is handed off to the output register.
// After reset a clearing pass over all TABLE_ENTRIES slots empties the table with the input stalled.
// A stalled result sits in the output register while loads keep being accepted; a select
// that finishes meanwhile waits for that register to drain.
module greedy_pair_select_invalidate_unit #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  gpsi_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output gpsi_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [gpsi_pkg::CFG_BITS-1:0]       i_cfg_wdata
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_KILL,
        S_DONE
    } t_state;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [CW-1:0]                 r_limit, n_limit;
    logic                          r_pend, n_pend;
    logic [AW-1:0]                 r_pend_addr, n_pend_addr;
    logic [gpsi_pkg::CFG_BITS-1:0] r_entries_in_use;
    logic                          r_out_valid, n_out_valid;
    gpsi_pkg::t_out_item           r_out, n_out;

    logic                          w_accept;
    logic                          w_mem_we;
    logic [AW-1:0]                 w_mem_waddr;
    gpsi_pkg::t_slot               w_mem_wdata;
    logic                          w_mem_re;
    gpsi_pkg::t_slot               w_rdata;
    logic                          w_clear_best;
    logic                          w_take;
    gpsi_pkg::t_out_item           w_best;
    logic                          w_conflict;
    logic [31:0]                   w_cfg_wide;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_cfg_wide = 32'(r_entries_in_use);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= '0;
        end else if (i_cfg_we) begin
            r_entries_in_use <= i_cfg_wdata;
        end
    end

    gpsi_table #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_rdata)
    );

    gpsi_pick #(
        .AW (AW)
    ) u_pick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_clear_best),
        .i_take     (w_take),
        .i_slot     (w_rdata),
        .i_addr     (r_pend_addr),
        .o_best     (w_best),
        .o_conflict (w_conflict)
    );

    // Sequencer next state: clearing pass, search, conflict sweep and hand-off.
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_limit      = r_limit;
        n_pend       = 1'b0;
        n_pend_addr  = r_cnt[AW-1:0];
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        w_mem_we     = 1'b0;
        w_mem_waddr  = r_cnt[AW-1:0];
        w_mem_wdata  = '0;
        w_mem_re     = 1'b0;
        w_clear_best = 1'b0;
        w_take       = 1'b0;

        // The downstream side takes the held result.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_mem_we = 1'b1;
                n_cnt    = r_cnt + CW'(1);
                if (r_cnt == CW'(TABLE_ENTRIES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.mode == gpsi_pkg::MODE_LOAD) begin
                        // Loads beyond the table are dropped.
                        if (32'(i_in.entry_index) < 32'(TABLE_ENTRIES)) begin
                            w_mem_we               = 1'b1;
                            w_mem_waddr            = AW'(i_in.entry_index);
                            w_mem_wdata.valid      = 1'b1;
                            w_mem_wdata.score      = i_in.evidence_value;
                            w_mem_wdata.first_var  = i_in.first_var;
                            w_mem_wdata.second_var = i_in.second_var;
                        end
                    end else begin
                        // A limit above the table size scans the whole table.
                        if (w_cfg_wide > 32'(TABLE_ENTRIES)) begin
                            n_limit = CW'(TABLE_ENTRIES);
                        end else begin
                            n_limit = CW'(w_cfg_wide);
                        end
                        n_cnt        = '0;
                        w_clear_best = 1'b1;
                        n_state      = S_FIND;
                    end
                end
            end
            S_FIND: begin
                w_take = r_pend;
                if (r_cnt != r_limit) begin
                    w_mem_re = 1'b1;
                    n_pend   = 1'b1;
                    n_cnt    = r_cnt + CW'(1);
                end else if (!r_pend) begin
                    n_cnt   = '0;
                    n_state = w_best.found ? S_KILL : S_DONE;
                end
            end
            S_KILL: begin
                // Write back a conflicting slot read last cycle with its valid flag dropped.
                if (r_pend && w_conflict) begin
                    w_mem_we          = 1'b1;
                    w_mem_waddr       = r_pend_addr;
                    w_mem_wdata       = w_rdata;
                    w_mem_wdata.valid = 1'b0;
                end
                if (r_cnt != CW'(TABLE_ENTRIES)) begin
                    w_mem_re = 1'b1;
                    n_pend   = 1'b1;
                    n_cnt    = r_cnt + CW'(1);
                end else if (!r_pend) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = w_best;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_limit     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_limit     <= n_limit;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_out       <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hdl/gpsi_check.sv
// Port-level checker for the pair select unit, attached to the top level by bind.
// Depends on gpsi_pkg and the assertion macro header.
`include "greedy_pair_select_invalidate_unit_macros.svh"

module gpsi_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  gpsi_pkg::t_in_item                  i_in,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  gpsi_pkg::t_out_item                 o_out
);

    // Reset leaves the input stalled for the clearing pass and no result pending.
    `GPSI_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> o_in_stall && !o_out_valid, "reset state wrong")

    // A stalled result holds.
    `GPSI_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out), "stalled result changed")

    // An empty result carries zeros in every field.
    `GPSI_ASSERT(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_out.found |-> o_out.best_index == '0 && o_out.best_evidence == '0 && o_out.best_first_var == '0 && o_out.best_second_var == '0, "empty result not zero")

    // A select transfer keeps the input stalled while it works.
    `GPSI_ASSERT(a_select_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in.mode == gpsi_pkg::MODE_SELECT |=> o_in_stall, "select did not stall input")

    // A new result appears only at the end of a select, while the input was stalled.
    `GPSI_ASSERT(a_result_source, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "result without select")

endmodule

bind greedy_pair_select_invalidate_unit gpsi_check u_gpsi_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
